FILE: sv/acfe_pkg.sv
// Package for the air-conditioner IR frame encoder.
// Holds payload widths, register map, frame constants and the frame builder.
// No dependencies.
package acfe_pkg;

  localparam int unsigned TickW      = 15;
  localparam int unsigned NumRegs    = 6;
  localparam int unsigned AddrW      = 5;
  localparam int unsigned FrameBits  = 56;
  localparam int unsigned NumSymbols = FrameBits + 2;
  localparam int unsigned CntW       = $clog2(NumSymbols);

  typedef logic [TickW-1:0] tick_t;
  typedef logic [CntW-1:0]  sym_cnt_t;
  typedef logic [FrameBits-1:0] frame_t;

  typedef enum logic [2:0] {
    REG_LEADER_MARK   = 3'd0,
    REG_LEADER_SPACE  = 3'd1,
    REG_BIT_MARK      = 3'd2,
    REG_ONE_SPACE     = 3'd3,
    REG_ZERO_SPACE    = 3'd4,
    REG_TRAILER_SPACE = 3'd5
  } reg_idx_t;

  localparam tick_t RstLeaderMark   = tick_t'(3500);
  localparam tick_t RstLeaderSpace  = tick_t'(1700);
  localparam tick_t RstBitMark      = tick_t'(500);
  localparam tick_t RstOneSpace     = tick_t'(1300);
  localparam tick_t RstZeroSpace    = tick_t'(360);
  localparam tick_t RstTrailerSpace = tick_t'(10700);

  localparam logic [1:0] SelSettings = 2'd0;
  localparam logic [1:0] SelOnTimer  = 2'd1;
  localparam logic [1:0] SelOffTimer = 2'd2;

  localparam logic [1:0] PwrOff = 2'd1;
  localparam logic [1:0] PwrOn  = 2'd2;

  localparam logic [7:0] Hdr0      = 8'h28;
  localparam logic [7:0] Hdr1      = 8'h61;
  localparam logic [7:0] HdrSet    = 8'h3d;
  localparam logic [7:0] HdrOnTmr  = 8'h6d;
  localparam logic [7:0] HdrOffTmr = 8'hcd;
  localparam logic [7:0] FanBase   = 8'h10;

  function automatic logic [3:0] mode_code(input logic [1:0] mode);
    logic [3:0] c;
    case (mode)
      2'd0:    c = 4'h1;
      2'd1:    c = 4'h5;
      2'd2:    c = 4'h9;
      default: c = 4'hd;
    endcase
    return c;
  endfunction

  function automatic frame_t build_frame(
    input logic [1:0] sel,
    input logic [1:0] mode,
    input logic [4:0] temp,
    input logic [1:0] fan,
    input logic [1:0] power,
    input logic [1:0] tkind,
    input logic [7:0] hours
  );
    logic [3:0] code;
    logic [7:0] b2, b3, b5, t8, t7;
    code = mode_code(mode);
    if (power == PwrOff) begin
      code = code + 4'd1;
    end else if (power == PwrOn) begin
      code = code + 4'd2;
    end
    t8 = 8'h00;
    t7 = 8'h00;
    if (tkind == sel) begin
      t8 = {hours[4:0], 3'b000};
      t7 = t8 - hours;
    end
    if (sel == SelSettings) begin
      b2 = HdrSet;
      b3 = FanBase + {6'd0, fan};
      b5 = {code, temp[3:0]};
    end else begin
      b2 = (sel == SelOnTimer) ? HdrOnTmr : HdrOffTmr;
      b3 = t8;
      b5 = t7;
    end
    return {~b5, b5, ~b3, b3, b2, Hdr1, Hdr0};
  endfunction

endpackage

FILE: sv/acfe_if.sv
// Handshake channels for the air-conditioner IR frame encoder.
// Depends on acfe_pkg for the tick width.
interface acfe_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_select;
  logic [1:0] ac_mode;
  logic [4:0] set_temp;
  logic [1:0] fan_speed;
  logic [1:0] power_action;
  logic [1:0] timer_kind;
  logic [7:0] timer_hours;

  modport source (output valid, frame_select, ac_mode, set_temp, fan_speed,
                  power_action, timer_kind, timer_hours, input ready);
  modport sink (input valid, frame_select, ac_mode, set_temp, fan_speed,
                power_action, timer_kind, timer_hours, output ready);
endinterface

interface acfe_sym_if;
  logic                      valid;
  logic                      ready;
  logic [acfe_pkg::TickW-1:0] mark_ticks;
  logic [acfe_pkg::TickW-1:0] space_ticks;
  logic                      last_symbol;

  modport source (output valid, mark_ticks, space_ticks, last_symbol, input ready);
  modport sink (input valid, mark_ticks, space_ticks, last_symbol, output ready);
endinterface

FILE: sv/ir_air_conditioner_frame_encoder_top.sv
// Air-conditioner IR frame encoder: one request in, 58 mark/space symbols out.
// A request is built into the pending register, loaded into the shift register
//   and sent as registered symbols, one per cycle unless out_ch.ready stalls;
//   the next request waits in a one-deep request register and its frame
//   follows the trailer. Reset (rst_n, synchronous, active low) clears all
//   control and loads timing defaults. Depends on acfe_pkg and acfe_if.
module ir_air_conditioner_frame_encoder_top (
  input  logic                        clk,
  input  logic                        rst_n,
  acfe_req_if.sink                    in_ch,
  acfe_sym_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [acfe_pkg::AddrW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import acfe_pkg::*;

  tick_t    regs_r [NumRegs];
  logic     pend_vld_r, pend_vld_nxt;
  frame_t   pend_frm_r, pend_frm_nxt;
  logic     act_r, act_nxt;
  sym_cnt_t cnt_r, cnt_nxt;
  frame_t   dat_r, dat_nxt;
  logic     ovld_r, ovld_nxt;
  tick_t    mark_r, mark_nxt;
  tick_t    space_r, space_nxt;
  logic     last_r, last_nxt;

  logic     req_xfer, fire, at_trailer, load;
  reg_idx_t widx;
  logic [2:0] ridx;

  assign cfg_pready = 1'b1;
  assign widx       = reg_idx_t'(cfg_paddr[AddrW-1:2]);
  assign ridx       = cfg_paddr[AddrW-1:2];

  always_comb begin
    cfg_prdata = 32'd0;
    if (ridx < 3'(NumRegs)) begin
      cfg_prdata = {17'd0, regs_r[ridx]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[REG_LEADER_MARK]   <= RstLeaderMark;
      regs_r[REG_LEADER_SPACE]  <= RstLeaderSpace;
      regs_r[REG_BIT_MARK]      <= RstBitMark;
      regs_r[REG_ONE_SPACE]     <= RstOneSpace;
      regs_r[REG_ZERO_SPACE]    <= RstZeroSpace;
      regs_r[REG_TRAILER_SPACE] <= RstTrailerSpace;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && ridx < 3'(NumRegs)) begin
      regs_r[widx] <= cfg_pwdata[TickW-1:0];
    end
  end

  assign fire       = act_r && (!ovld_r || out_ch.ready);
  assign at_trailer = (cnt_r == sym_cnt_t'(NumSymbols - 1));
  assign load       = pend_vld_r && (!act_r || (fire && at_trailer));
  assign in_ch.ready = !pend_vld_r || load;
  assign req_xfer   = in_ch.valid && in_ch.ready;

  always_comb begin
    pend_vld_nxt = pend_vld_r;
    pend_frm_nxt = pend_frm_r;
    if (load) begin
      pend_vld_nxt = 1'b0;
    end
    if (req_xfer && in_ch.frame_select != 2'd3) begin
      pend_vld_nxt = 1'b1;
      pend_frm_nxt = build_frame(in_ch.frame_select, in_ch.ac_mode, in_ch.set_temp,
                                 in_ch.fan_speed, in_ch.power_action,
                                 in_ch.timer_kind, in_ch.timer_hours);
    end
  end

  always_comb begin
    act_nxt   = act_r;
    cnt_nxt   = cnt_r;
    dat_nxt   = dat_r;
    ovld_nxt  = ovld_r && !out_ch.ready;
    mark_nxt  = mark_r;
    space_nxt = space_r;
    last_nxt  = last_r;
    if (fire) begin
      ovld_nxt = 1'b1;
      last_nxt = 1'b0;
      if (cnt_r == '0) begin
        mark_nxt  = regs_r[REG_LEADER_MARK];
        space_nxt = regs_r[REG_LEADER_SPACE];
      end else if (at_trailer) begin
        mark_nxt  = regs_r[REG_BIT_MARK];
        space_nxt = regs_r[REG_TRAILER_SPACE];
        last_nxt  = 1'b1;
        act_nxt   = 1'b0;
      end else begin
        mark_nxt  = regs_r[REG_BIT_MARK];
        space_nxt = dat_r[0] ? regs_r[REG_ONE_SPACE] : regs_r[REG_ZERO_SPACE];
        dat_nxt   = dat_r >> 1;
      end
      cnt_nxt = cnt_r + sym_cnt_t'(1);
    end
    if (load) begin
      act_nxt = 1'b1;
      cnt_nxt = '0;
      dat_nxt = pend_frm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      act_r      <= 1'b0;
      cnt_r      <= '0;
      ovld_r     <= 1'b0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
      act_r      <= act_nxt;
      cnt_r      <= cnt_nxt;
      ovld_r     <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_frm_r <= pend_frm_nxt;
    dat_r      <= dat_nxt;
    mark_r     <= mark_nxt;
    space_r    <= space_nxt;
    last_r     <= last_nxt;
  end

  assign out_ch.valid       = ovld_r;
  assign out_ch.mark_ticks  = mark_r;
  assign out_ch.space_ticks = space_r;
  assign out_ch.last_symbol = last_r;

  a_trailer_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    fire && at_trailer |=> ovld_r && last_r)
    else $error("trailer not flagged last");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    act_r |-> cnt_r <= sym_cnt_t'(NumSymbols - 1))
    else $error("symbol counter out of range");

  a_load_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> act_r && cnt_r == '0)
    else $error("frame load did not restart counter");

  a_pend_held: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r && !load |=> pend_vld_r)
    else $error("pending request lost");

  a_last_only_trailer: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !at_trailer |=> !last_r)
    else $error("last set on a non-trailer symbol");

endmodule
